// ----- rtl/core/size_class_block_allocator_top_assert.svh -----
// assertion macros for the allocator top
`ifndef SIZE_CLASS_BLOCK_ALLOCATOR_TOP_ASSERT_SVH
`define SIZE_CLASS_BLOCK_ALLOCATOR_TOP_ASSERT_SVH

// same-cycle implication, ignored while reset is held
`define SCBA_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("scba assertion failed");

// next-cycle implication, ignored while reset is held
`define SCBA_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("scba assertion failed");

`endif

// ----- rtl/core/scba_pkg.sv -----
package scba_pkg;

    localparam int NUM_CLASSES_DEF = 20;
    localparam int LIST_DEPTH_DEF  = 256;
    localparam int ADDR_BITS_DEF   = 32;

    localparam int DATA_W    = 32;
    localparam int CLASS_W   = 5;
    localparam int TAG_W     = 8;
    localparam int FREE_W    = 9;
    localparam int THR_W     = 11;
    localparam int CFG_IDX_W = 2;

    localparam logic [TAG_W-1:0]  OUTSIDE_TAG    = 8'hff;
    localparam logic [DATA_W-1:0] HDR_BYTES      = 32'd8;
    localparam logic [DATA_W-1:0] POOL_BYTES_RST = 32'h0010_0000;

    localparam logic [CFG_IDX_W-1:0] CFG_POOL_BASE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_POOL_BYTES = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_REFILL_THR = 2'd2;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    typedef enum logic [2:0] {
        ST_LIST      = 3'd0,
        ST_POOL      = 3'd1,
        ST_TOO_LARGE = 3'd2,
        ST_NO_MEM    = 3'd3,
        ST_FREED     = 3'd4,
        ST_LIST_FULL = 3'd5,
        ST_NULL      = 3'd6,
        ST_OUTSIDE   = 3'd7
    } t_status;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_EXEC = 1'b1
    } t_state;

    // decoded request: early means no class is touched and no state changes
    typedef struct packed {
        logic               early;
        t_status            status;
        logic [CLASS_W-1:0] cls;
    } t_dec;

endpackage

// ----- rtl/core/scba_req_if.sv -----
interface scba_req_if;
    logic                                valid;
    logic                                ready;
    logic                                opcode;
    logic [scba_pkg::DATA_W-1:0]         req_size;
    logic [scba_pkg::DATA_W-1:0]         block_address;
    logic [scba_pkg::TAG_W-1:0]          class_tag;

    modport source (
        output valid, opcode, req_size, block_address, class_tag,
        input  ready
    );
    modport sink (
        input  valid, opcode, req_size, block_address, class_tag,
        output ready
    );
endinterface

// ----- rtl/core/scba_rsp_if.sv -----
interface scba_rsp_if;
    logic                            valid;
    logic                            ready;
    scba_pkg::t_status               status;
    logic [scba_pkg::DATA_W-1:0]     address;
    logic [scba_pkg::CLASS_W-1:0]    size_class;
    logic [scba_pkg::DATA_W-1:0]     class_in_use;
    logic [scba_pkg::FREE_W-1:0]     class_free;
    logic [scba_pkg::FREE_W-1:0]     class_peak;
    logic [scba_pkg::DATA_W-1:0]     used_bytes;
    logic                            refill_wanted;

    modport source (
        output valid, status, address, size_class, class_in_use, class_free,
               class_peak, used_bytes, refill_wanted,
        input  ready
    );
    modport sink (
        input  valid, status, address, size_class, class_in_use, class_free,
               class_peak, used_bytes, refill_wanted,
        output ready
    );
endinterface

// ----- rtl/core/scba_ram.sv -----
module scba_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/core/scba_dec.sv -----
module scba_dec #(
    parameter int NUM_CLASSES = scba_pkg::NUM_CLASSES_DEF
) (
    input  logic                          i_opcode,
    input  logic [scba_pkg::DATA_W-1:0]   i_req_size,
    input  logic [scba_pkg::DATA_W-1:0]   i_block_address,
    input  logic [scba_pkg::TAG_W-1:0]    i_class_tag,
    output scba_pkg::t_dec                o_dec
);

    localparam int SHIFT_W = scba_pkg::DATA_W - 3;

    logic [SHIFT_W-1:0]           units;
    logic [scba_pkg::CLASS_W-1:0] bit_len;
    logic                         too_large;
    logic                         tag_ok;

    assign units     = i_req_size[scba_pkg::DATA_W-1:3];
    // size at or above 8 << (classes - 1)
    assign too_large = (i_req_size >> (NUM_CLASSES + 2)) != '0;
    assign tag_ok    = (i_class_tag != scba_pkg::OUTSIDE_TAG)
                    && ({24'd0, i_class_tag} < 32'(NUM_CLASSES));

    // bit length of size >> 3
    always_comb begin
        bit_len = '0;
        for (int i = 0; i < SHIFT_W; i++) begin
            if (units[i]) begin
                bit_len = scba_pkg::CLASS_W'(i + 1);
            end
        end
    end

    always_comb begin
        o_dec.early  = 1'b0;
        o_dec.status = scba_pkg::ST_LIST;
        o_dec.cls    = '0;
        if (i_opcode == scba_pkg::OP_ALLOC) begin
            if (too_large) begin
                o_dec.early  = 1'b1;
                o_dec.status = scba_pkg::ST_TOO_LARGE;
            end else begin
                o_dec.cls = bit_len;
            end
        end else begin
            priority if (i_block_address == '0) begin
                o_dec.early  = 1'b1;
                o_dec.status = scba_pkg::ST_NULL;
            end else if (!tag_ok) begin
                o_dec.early  = 1'b1;
                o_dec.status = scba_pkg::ST_OUTSIDE;
            end else begin
                o_dec.cls = i_class_tag[scba_pkg::CLASS_W-1:0];
            end
        end
    end

endmodule

// ----- rtl/core/size_class_block_allocator_top.sv -----
// Size-class block allocator. Every transaction gives one result: on acceptance
// the request is decoded and the free stack entry and the class counters are read
// from their memories; in the execute state the stack entry, fill level and
// counters are updated where the request changes them, and once the output
// register is free or being taken the result is loaded into it. A new request is
// taken only after the last one has loaded its result, since ready is high only
// while idle. Both memories have a registered read port. The stack memory holds
// NUM_CLASSES x LIST_DEPTH addresses and is never cleared: only entries that were
// pushed are ever popped. Stack fill levels live in flip-flops and the in-use and
// peak counters carry a valid bit per class, so the block is ready right after
// reset. Configuration registers must only be written while no transaction is in flight.
module size_class_block_allocator_top #(
    parameter int NUM_CLASSES = scba_pkg::NUM_CLASSES_DEF,
    parameter int LIST_DEPTH  = scba_pkg::LIST_DEPTH_DEF,
    parameter int ADDR_BITS   = scba_pkg::ADDR_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    scba_req_if.sink                       i_req,
    scba_rsp_if.source                     o_rsp,
    input  logic                           i_cfg_we,
    input  logic [scba_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [scba_pkg::DATA_W-1:0]    i_cfg_data
);

    localparam int CLS_W     = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
    localparam int IDX_W     = $clog2(LIST_DEPTH);
    localparam int FILL_W    = $clog2(LIST_DEPTH + 1);
    localparam int STK_DEPTH = NUM_CLASSES << IDX_W;
    localparam int STK_AW    = $clog2(STK_DEPTH);
    localparam int CNT_W     = scba_pkg::DATA_W + FILL_W;
    localparam int PROD_W    = scba_pkg::THR_W + 1 + scba_pkg::DATA_W;
    localparam int DW        = scba_pkg::DATA_W;

    // configuration
    logic [DW-1:0]                 r_pool_base;
    logic [DW-1:0]                 r_pool_bytes;
    logic [scba_pkg::THR_W-1:0]    r_refill_thr;
    logic [PROD_W-1:0]             r_thr_prod;

    // control and class state
    scba_pkg::t_state              r_state, n_state;
    logic [FILL_W-1:0]             r_fill [NUM_CLASSES];
    logic [NUM_CLASSES-1:0]        r_cnt_vld;
    logic [DW-1:0]                 r_bump;

    // request held for the execute state
    logic                          r_op;
    logic [CLS_W-1:0]              r_cls;
    logic [DW-1:0]                 r_baddr;
    logic                          r_early;
    scba_pkg::t_status             r_early_st;

    // output register
    logic                          r_out_valid;
    scba_pkg::t_status             r_out_status;
    logic [DW-1:0]                 r_out_addr;
    logic [scba_pkg::CLASS_W-1:0]  r_out_cls;
    logic [DW-1:0]                 r_out_use;
    logic [scba_pkg::FREE_W-1:0]   r_out_free;
    logic [scba_pkg::FREE_W-1:0]   r_out_peak;
    logic [DW-1:0]                 r_out_used;
    logic                          r_out_refill;

    scba_pkg::t_dec                dec;
    logic [CLS_W-1:0]              dec_cls;
    logic [FILL_W-1:0]             dec_fill;
    logic                          accept;
    logic                          fire;

    logic                          stk_we;
    logic [STK_AW-1:0]             stk_waddr;
    logic [STK_AW-1:0]             stk_raddr;
    logic [ADDR_BITS-1:0]          stk_rdata;
    logic [CNT_W-1:0]              cnt_rdata;
    logic                          cnt_we;

    logic [FILL_W-1:0]             cur_fill;
    logic [DW-1:0]                 cur_use;
    logic [FILL_W-1:0]             cur_peak;
    logic [FILL_W-1:0]             new_fill;
    logic [DW-1:0]                 new_use;
    logic [FILL_W-1:0]             new_peak;
    logic [DW-1:0]                 n_bump;
    logic [DW-1:0]                 res_addr;
    scba_pkg::t_status             res_status;
    logic                          fill_upd;
    logic [DW+1:0]                 need;
    logic                          fits;
    logic [65:0]                   pool_sum;
    logic [ADDR_BITS-1:0]          pool_addr;
    logic                          refill;

    scba_dec #(
        .NUM_CLASSES (NUM_CLASSES)
    ) u_dec (
        .i_opcode        (i_req.opcode),
        .i_req_size      (i_req.req_size),
        .i_block_address (i_req.block_address),
        .i_class_tag     (i_req.class_tag),
        .o_dec           (dec)
    );

    assign dec_cls  = dec.cls[CLS_W-1:0];
    assign dec_fill = r_fill[dec_cls];

    // pop reads the top entry, push needs no read data
    always_comb begin
        if (i_req.opcode == scba_pkg::OP_ALLOC) begin
            stk_raddr = STK_AW'({dec_cls, IDX_W'(dec_fill - FILL_W'(1))});
        end else begin
            stk_raddr = STK_AW'({dec_cls, dec_fill[IDX_W-1:0]});
        end
    end

    scba_ram #(
        .WIDTH (ADDR_BITS),
        .DEPTH (STK_DEPTH)
    ) u_stack_ram (
        .i_clk   (i_clk),
        .i_we    (stk_we),
        .i_waddr (stk_waddr),
        .i_wdata (ADDR_BITS'(r_baddr)),
        .i_re    (accept),
        .i_raddr (stk_raddr),
        .o_rdata (stk_rdata)
    );

    scba_ram #(
        .WIDTH (CNT_W),
        .DEPTH (NUM_CLASSES)
    ) u_count_ram (
        .i_clk   (i_clk),
        .i_we    (cnt_we),
        .i_waddr (r_cls),
        .i_wdata ({new_peak, new_use}),
        .i_re    (accept),
        .i_raddr (dec_cls),
        .o_rdata (cnt_rdata)
    );

    // handshake and sequencing
    always_comb begin
        n_state     = r_state;
        i_req.ready = 1'b0;
        fire        = 1'b0;
        unique case (r_state)
            scba_pkg::S_IDLE: begin
                i_req.ready = 1'b1;
                if (i_req.valid) begin
                    n_state = scba_pkg::S_EXEC;
                end
            end
            scba_pkg::S_EXEC: begin
                if (!r_out_valid || o_rsp.ready) begin
                    fire    = 1'b1;
                    n_state = scba_pkg::S_IDLE;
                end
            end
            default: n_state = scba_pkg::S_IDLE;
        endcase
    end

    assign accept = i_req.valid && i_req.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= scba_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // execute: modify what was read
    assign cur_fill = r_fill[r_cls];
    assign cur_use  = r_cnt_vld[r_cls] ? cnt_rdata[DW-1:0] : '0;
    assign cur_peak = r_cnt_vld[r_cls] ? cnt_rdata[CNT_W-1:DW] : '0;
    assign need     = ((DW+2)'(8) << r_cls) + (DW+2)'(scba_pkg::HDR_BYTES);
    assign fits     = ({2'b00, r_bump} + need) < {2'b00, r_pool_bytes};
    assign pool_sum = 66'(r_pool_base) + 66'(r_bump) + 66'(scba_pkg::HDR_BYTES);
    assign pool_addr = pool_sum[ADDR_BITS-1:0];

    always_comb begin
        res_status = r_early_st;
        res_addr   = '0;
        new_fill   = cur_fill;
        new_use    = cur_use;
        new_peak   = cur_peak;
        n_bump     = r_bump;
        fill_upd   = 1'b0;
        stk_we     = 1'b0;
        cnt_we     = 1'b0;
        stk_waddr  = STK_AW'({r_cls, cur_fill[IDX_W-1:0]});
        if (!r_early) begin
            if (r_op == scba_pkg::OP_ALLOC) begin
                priority if (cur_fill != '0) begin
                    res_status = scba_pkg::ST_LIST;
                    res_addr   = DW'(stk_rdata);
                    new_fill   = cur_fill - FILL_W'(1);
                    new_use    = cur_use + DW'(1);
                    fill_upd   = fire;
                    cnt_we     = fire;
                end else if (fits) begin
                    res_status = scba_pkg::ST_POOL;
                    res_addr   = DW'(pool_addr);
                    new_use    = cur_use + DW'(1);
                    n_bump     = r_bump + need[DW-1:0];
                    cnt_we     = fire;
                end else begin
                    res_status = scba_pkg::ST_NO_MEM;
                end
            end else begin
                if (cur_fill == FILL_W'(LIST_DEPTH)) begin
                    res_status = scba_pkg::ST_LIST_FULL;
                end else begin
                    res_status = scba_pkg::ST_FREED;
                    new_fill   = cur_fill + FILL_W'(1);
                    new_use    = cur_use - DW'(1);
                    if (cur_peak < new_fill) begin
                        new_peak = new_fill;
                    end
                    fill_upd   = fire;
                    stk_we     = fire;
                    cnt_we     = fire;
                end
            end
        end
    end

    // floor(used * 1024 / bytes) > thr  <=>  used * 1024 >= (thr + 1) * bytes
    assign refill = (r_pool_bytes != '0)
                 && (PROD_W'({n_bump, 10'd0}) >= r_thr_prod);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pool_base  <= '0;
            r_pool_bytes <= scba_pkg::POOL_BYTES_RST;
            r_refill_thr <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                scba_pkg::CFG_POOL_BASE:  r_pool_base  <= i_cfg_data;
                scba_pkg::CFG_POOL_BYTES: r_pool_bytes <= i_cfg_data;
                scba_pkg::CFG_REFILL_THR: r_refill_thr <= i_cfg_data[scba_pkg::THR_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_thr_prod <= PROD_W'({1'b0, r_refill_thr} + 12'd1) * PROD_W'(r_pool_bytes);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bump    <= '0;
            r_cnt_vld <= '0;
            for (int c = 0; c < NUM_CLASSES; c++) begin
                r_fill[c] <= '0;
            end
        end else if (fire) begin
            r_bump <= n_bump;
            if (fill_upd) begin
                r_fill[r_cls] <= new_fill;
            end
            if (cnt_we) begin
                r_cnt_vld[r_cls] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op       <= i_req.opcode;
            r_cls      <= dec_cls;
            r_baddr    <= i_req.block_address;
            r_early    <= dec.early;
            r_early_st <= dec.status;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out_status <= res_status;
            r_out_addr   <= res_addr;
            r_out_cls    <= r_early ? '0 : scba_pkg::CLASS_W'(r_cls);
            r_out_use    <= r_early ? '0 : new_use;
            r_out_free   <= r_early ? '0 : scba_pkg::FREE_W'(new_fill);
            r_out_peak   <= r_early ? '0 : scba_pkg::FREE_W'(new_peak);
            r_out_used   <= n_bump;
            r_out_refill <= refill;
        end
    end

    assign o_rsp.valid         = r_out_valid;
    assign o_rsp.status        = r_out_status;
    assign o_rsp.address       = r_out_addr;
    assign o_rsp.size_class    = r_out_cls;
    assign o_rsp.class_in_use  = r_out_use;
    assign o_rsp.class_free    = r_out_free;
    assign o_rsp.class_peak    = r_out_peak;
    assign o_rsp.used_bytes    = r_out_used;
    assign o_rsp.refill_wanted = r_out_refill;

`include "size_class_block_allocator_top_assert.svh"

    `SCBA_ASSERT_NOW(a_out_from_exec, i_clk, i_rst_n, $rose(r_out_valid), $past(r_state == scba_pkg::S_EXEC))
    `SCBA_ASSERT_NOW(a_fill_bound, i_clk, i_rst_n, r_state == scba_pkg::S_EXEC, r_fill[r_cls] <= FILL_W'(LIST_DEPTH))
    `SCBA_ASSERT_NOW(a_stack_port, i_clk, i_rst_n, stk_we, !accept)
    `SCBA_ASSERT_NEXT(a_bump_moves, i_clk, i_rst_n, fire && (res_status == scba_pkg::ST_POOL), r_bump != $past(r_bump))

endmodule
